/* hw/rtl/sac_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg
// Shared widths, operation codes and the cell control bundle for the sorted
// key array.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned FUNC_W        = 3;
  localparam int unsigned CAP_W         = 5;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_DEL_ONE = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_DEL_ALL = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FUNC_FIND    = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = FUNC_W'(4);

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot at the lower bound, shift the keys at and above it up
    logic del;  // drop the key at the lower bound, shift the keys above it down
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/sac_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_cell
// One slot of the sorted chain: holds a key, compares it to the search key
// and moves data to or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sac_cell
  import sac_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic              valid_i,     // slot lies below the fill count
  input  wire logic [KEY_W-1:0]  key_cmp_i,   // search key, also the key to insert
  input  wire logic              prev_lt_i,   // lower neighbor holds a smaller key
  input  wire logic [KEY_W-1:0]  prev_key_i,
  input  wire logic [KEY_W-1:0]  next_key_i,
  output logic      [KEY_W-1:0]  key_o,
  output logic                   lt_o,
  output logic                   eq_o
);

  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] key_d;

  assign lt_o  = valid_i && ($signed(key_q) < $signed(key_cmp_i));
  assign eq_o  = valid_i && (key_q == key_cmp_i);
  assign key_o = key_q;

  // cells below the lower bound never move
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && !lt_o) begin
      key_d = prev_lt_i ? key_cmp_i : prev_key_i;
    end else if (ctrl_i.del && !lt_o) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
`default_nettype wire

/* hw/rtl/sorted_key_array_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_array_core
// Sorted array of signed keys (duplicates kept) built as a chain of
// compare-and-shift cells: insert, delete one, delete all, find, clear.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o  | func_i, key_i
//  out     | out_valid_o / out_ready_i| position_o, found_o, insert_point_o,
//          |                          | occupancy_o
//  cfg     | cfg_we_i                 | cfg_data_i (capacity)
//
// An item is accepted in S_IDLE, then in S_RUN every cell compares in parallel
// and the chain shifts. Delete-all then removes the other copies, one per cycle,
// in S_SWEEP. One item is in work at a time.
// The result register frees the input side: a new item is taken while a
// result waits; the item then holds in its compare cycle until out frees.
// Reset empties the array at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_array_core
  import sac_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
)(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CAP_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [KEY_W-1:0]  key_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [POS_W-1:0]  position_o,
  output logic                   found_o,
  output logic      [POS_W-1:0]  insert_point_o,
  output logic      [POS_W-1:0]  occupancy_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SWEEP
  } state_e;

  state_e            state_q;
  logic [CAP_W-1:0]  cap_q;
  logic [CW-1:0]     fill_q;
  logic [CW-1:0]     fill_d;
  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;

  logic              out_valid_q;
  logic [POS_W-1:0]  pos_q;
  logic              found_q;
  logic [POS_W-1:0]  ip_q;
  logic [POS_W-1:0]  occ_q;

  cell_ctrl_t        ctrl;
  logic [DEPTH-1:0]  lt;
  logic [DEPTH-1:0]  eq;
  logic [KEY_W-1:0]  cell_key [DEPTH];
  logic [DEPTH:0]    bound_hot;
  logic [CW-1:0]     lb;
  logic [CMPW-1:0]   lb_ext;
  logic [CMPW-1:0]   fill_ext;
  logic [CMPW-1:0]   fill_d_ext;
  logic              any_eq;
  logic              can_ins;
  logic              slot_free;
  logic              run_go;
  logic              sweep_go;
  logic              is_del;
  logic              res_done;
  logic [POS_W-1:0]  pos_run;

  // ---- cell chain ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sac_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (CW'(i) < fill_q),
      .key_cmp_i  (key_q),
      .prev_lt_i  ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
      .prev_key_i (cell_key[(i == 0) ? 0 : i - 1]),
      .next_key_i (cell_key[(i == DEPTH - 1) ? i : i + 1]),
      .key_o      (cell_key[i]),
      .lt_o       (lt[i]),
      .eq_o       (eq[i])
    );
  end

  // lt is a thermometer code; its edge is the lower bound
  assign bound_hot = {lt, 1'b1} & ~{1'b0, lt};

  always_comb begin
    lb = '0;
    for (int i = 0; i <= DEPTH; i++) begin
      if (bound_hot[i]) begin
        lb = lb | CW'(i);
      end
    end
  end

  assign any_eq     = |eq;
  assign lb_ext     = CMPW'(lb);
  assign fill_ext   = CMPW'(fill_q);
  assign fill_d_ext = CMPW'(fill_d);
  assign can_ins    = (fill_ext < CMPW'(cap_q)) && (fill_q < DEPTH_C);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign run_go     = (state_q == S_RUN) && slot_free;
  assign sweep_go   = (state_q == S_SWEEP);
  assign is_del     = (func_q == FUNC_DEL_ONE) || (func_q == FUNC_DEL_ALL);
  // the item's result is ready to load this cycle
  assign res_done   = (run_go && !((func_q == FUNC_DEL_ALL) && any_eq)) ||
                      (sweep_go && !any_eq);

  assign ctrl.ins = run_go && (func_q == FUNC_INSERT) && can_ins;
  assign ctrl.del = ((run_go && is_del) || sweep_go) && any_eq;

  always_comb begin
    fill_d = fill_q;
    if (ctrl.ins) begin
      fill_d = fill_q + CW'(1);
    end else if (ctrl.del) begin
      fill_d = fill_q - CW'(1);
    end else if (run_go && (func_q == FUNC_CLEAR)) begin
      fill_d = '0;
    end
  end

  always_comb begin
    case (func_q)
      FUNC_INSERT: pos_run = can_ins ? lb_ext[POS_W-1:0] : '1;
      FUNC_CLEAR:  pos_run = '1;
      default:     pos_run = any_eq ? lb_ext[POS_W-1:0] : '1;
    endcase
  end

  // ---- control, state and result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      fill_q      <= '0;
      func_q      <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      ip_q        <= '0;
      occ_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      if (res_done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            key_q   <= key_i;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (slot_free) begin
            pos_q   <= pos_run;
            found_q <= any_eq;
            ip_q    <= lb_ext[POS_W-1:0];
            if ((func_q == FUNC_DEL_ALL) && any_eq) begin
              state_q <= S_SWEEP;
            end else begin
              occ_q       <= fill_d_ext[POS_W-1:0];
              state_q     <= S_IDLE;
            end
          end
        end
        S_SWEEP: begin
          // the rest of the run sits at the same lower bound
          if (!any_eq) begin
            occ_q       <= fill_ext[POS_W-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_q;
  assign found_o        = found_q;
  assign insert_point_o = ip_q;
  assign occupancy_o    = occ_q;

  // ---- checks ----
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_C)
    else $error("fill count above depth");

  a_sweep_del_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (func_q == FUNC_DEL_ALL))
    else $error("sweep outside delete-all");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (fill_q == $past(fill_q) + CW'(1)))
    else $error("insert did not grow fill count");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != S_IDLE))
    else $error("result raised without an item in work");

  a_no_shift_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!ctrl.ins && !ctrl.del))
    else $error("chain moved while idle");

endmodule
`default_nettype wire
